/* rtl/fci_pkg.sv */
// shared types, constants and coding functions for the convolutional interleave encoder
`timescale 1ns / 1ps
package fci_pkg;

   // register map, indexed by paddr[2]
   localparam logic REG_APPEND_CRC = 1'b0;
   localparam logic REG_CRC_POLY   = 1'b1;

   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY_INIT = 16'h8005;
   localparam logic [7:0]  TERM_BYTE     = 8'h0B;

   // code symbol per input bit and three memory bits
   localparam logic [1:0] CODE_TABLE [16] = '{
      2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1,
      2'd3, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd1, 2'd2
   };

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } fci_req_type;

   typedef struct packed {
      logic [7:0] coded_byte;
      logic       end_of_packet;
   } fci_rsp_type;

   // one byte offered to the coder
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
   } fci_feed_type;

   // four interleaved bytes handed to the output buffer
   typedef struct packed {
      logic        valid;
      logic [31:0] bytes;
      logic        eop;
   } fci_load_type;

   // crc-16, msb first, one byte
   function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                              input logic [7:0]  b,
                                              input logic [15:0] poly);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int k = 0; k < 8; k++) begin
         fb = c[15] ^ b[7 - k];
         c  = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ poly;
         end
      end
      return c;
   endfunction

   // rate 1/2 code word of one byte given the encoder memory
   function automatic logic [15:0] conv_encode(input logic [2:0] mem,
                                               input logic [7:0] b);
      logic [10:0] r;
      logic [15:0] w;
      r = {mem, b};
      w = '0;
      for (int i = 0; i < 8; i++) begin
         w[2*i +: 2] = CODE_TABLE[r[i +: 4]];
      end
      return w;
   endfunction

   // bit-pair interleave of two code words, first output byte in the top bits
   function automatic logic [31:0] interleave(input logic [15:0] held,
                                              input logic [15:0] w);
      logic [31:0] v;
      v = '0;
      for (int n = 0; n < 4; n++) begin
         v[8*(3-n) +: 8] = {w[2*n +: 2], w[8+2*n +: 2], held[2*n +: 2], held[8+2*n +: 2]};
      end
      return v;
   endfunction

endpackage

/* rtl/fci_tail_seq.sv */
// input register, running crc and packet tail sequencer
`timescale 1ns / 1ps
module fci_tail_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  fci_pkg::fci_req_type req_word,
   input  logic                 append_crc,
   input  logic [15:0]          crc_polynomial,
   input  logic                 phase,
   input  logic                 feed_take,
   output fci_pkg::fci_feed_type feed
);
   import fci_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DATA   = 3'd1;
   localparam logic [2:0] ST_CRC_HI = 3'd2;
   localparam logic [2:0] ST_CRC_LO = 3'd3;
   localparam logic [2:0] ST_TERM   = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [7:0]  data_ff, data_in;
   logic        last_ff, last_in;
   logic [15:0] crc_ff, crc_in;
   logic [2:0]  term_cnt_ff, term_cnt_in;
   logic        data_done;
   logic        tail_done;
   logic        accept;

   always_comb begin
      feed.valid = (state_ff != ST_IDLE);
      feed.last  = (state_ff == ST_TERM) && (term_cnt_ff == 3'd1);
      case (state_ff)
         ST_DATA:   feed.data = data_ff;
         ST_CRC_HI: feed.data = crc_ff[15:8];
         ST_CRC_LO: feed.data = crc_ff[7:0];
         default:   feed.data = TERM_BYTE;
      endcase
   end

   assign data_done = (state_ff == ST_DATA) && feed_take && !last_ff;
   assign tail_done = feed_take && feed.last;
   assign req_stall = !((state_ff == ST_IDLE) || data_done || tail_done);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in    = state_ff;
      data_in     = data_ff;
      last_in     = last_ff;
      crc_in      = crc_ff;
      term_cnt_in = term_cnt_ff;
      if (feed_take) begin
         case (state_ff)
            ST_DATA: begin
               crc_in = crc_update(crc_ff, data_ff, crc_polynomial);
               if (last_ff) begin
                  // two terminators plus one pad if a word is left unpaired, else two
                  term_cnt_in = phase ? 3'd4 : 3'd3;
                  state_in    = append_crc ? ST_CRC_HI : ST_TERM;
               end else begin
                  state_in = ST_IDLE;
               end
            end
            ST_CRC_HI: state_in = ST_CRC_LO;
            ST_CRC_LO: state_in = ST_TERM;
            ST_TERM: begin
               term_cnt_in = term_cnt_ff - 3'd1;
               if (term_cnt_ff == 3'd1) begin
                  state_in = ST_IDLE;
                  crc_in   = CRC_INIT;
               end
            end
            default: state_in = ST_IDLE;
         endcase
      end
      if (accept) begin
         data_in  = req_word.data_byte;
         last_in  = req_word.last_byte;
         state_in = ST_DATA;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         crc_ff      <= CRC_INIT;
         term_cnt_ff <= 3'd0;
      end else begin
         state_ff    <= state_in;
         crc_ff      <= crc_in;
         term_cnt_ff <= term_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   a_tail_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CRC_HI || state_ff == ST_CRC_LO ||
       (state_ff == ST_TERM && term_cnt_ff != 3'd1)) |-> req_stall)
      else $error("input accepted during packet tail");

   a_crc_reload: assert property (@(posedge clock) disable iff (reset)
      tail_done |=> (crc_ff == CRC_INIT))
      else $error("crc not reloaded after packet");

endmodule

/* rtl/fci_coder.sv */
// convolutional coder, word pairing and interleave
`timescale 1ns / 1ps
module fci_coder (
   input  logic                  clock,
   input  logic                  reset,
   input  fci_pkg::fci_feed_type feed,
   output logic                  feed_take,
   output logic                  phase,
   input  logic                  load_ok,
   output fci_pkg::fci_load_type load
);
   import fci_pkg::*;

   logic [2:0]  mem_ff, mem_in;
   logic        phase_ff, phase_in;
   logic [15:0] held_ff;
   logic [15:0] code_word;

   assign code_word = conv_encode(mem_ff, feed.data);
   assign feed_take = feed.valid && (!phase_ff || load_ok);
   assign phase     = phase_ff;

   assign load.valid = feed_take && phase_ff;
   assign load.bytes = interleave(held_ff, code_word);
   assign load.eop   = feed.last;

   always_comb begin
      mem_in   = mem_ff;
      phase_in = phase_ff;
      if (feed_take) begin
         // memory is the low three bits of the byte, cleared at packet end
         mem_in   = feed.last ? 3'd0 : feed.data[2:0];
         phase_in = !phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_ff   <= 3'd0;
         phase_ff <= 1'b0;
      end else begin
         mem_ff   <= mem_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (feed_take && !phase_ff) begin
         held_ff <= code_word;
      end
   end

   a_last_completes_pair: assert property (@(posedge clock) disable iff (reset)
      (feed.valid && feed.last) |-> phase_ff)
      else $error("packet end on an unpaired word");

   a_packet_end_clears: assert property (@(posedge clock) disable iff (reset)
      (feed_take && feed.last) |=> (mem_ff == 3'd0 && !phase_ff))
      else $error("coder state not cleared after packet");

endmodule

/* rtl/fci_out_buf.sv */
// four byte output buffer feeding the byte-wide result channel
`timescale 1ns / 1ps
module fci_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  fci_pkg::fci_load_type load,
   output logic                  load_ok,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output fci_pkg::fci_rsp_type  rsp_word
);
   import fci_pkg::*;

   logic [31:0] bytes_ff;
   logic        eop_ff;
   logic [1:0]  cnt_ff, cnt_in;
   logic        valid_ff, valid_in;
   logic        take;

   assign take    = valid_ff && !rsp_stall;
   assign load_ok = !valid_ff || (take && cnt_ff == 2'd3);

   assign rsp_valid = valid_ff;

   always_comb begin
      rsp_word.end_of_packet = eop_ff && (cnt_ff == 2'd3);
      case (cnt_ff)
         2'd0:    rsp_word.coded_byte = bytes_ff[31:24];
         2'd1:    rsp_word.coded_byte = bytes_ff[23:16];
         2'd2:    rsp_word.coded_byte = bytes_ff[15:8];
         default: rsp_word.coded_byte = bytes_ff[7:0];
      endcase
   end

   always_comb begin
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      if (take) begin
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            valid_in = 1'b0;
         end
      end
      if (load.valid) begin
         cnt_in   = 2'd0;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load.valid) begin
         bytes_ff <= load.bytes;
         eop_ff   <= load.eop;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load.valid |-> load_ok)
      else $error("output buffer overwritten before drained");

endmodule

/* rtl/fec_convolutional_interleave_encoder.sv */
// top level of the packet convolutional encoder with bit-pair interleaver
`timescale 1ns / 1ps
// Packet encoder: payload bytes come in on the req channel, each with a last flag, and
// coded bytes leave on the rsp channel, end_of_packet set on the final one of a packet.
// A running crc-16 (start 0xffff, msb first, polynomial from the crc_polynomial register)
// covers the payload; after the last byte the tail is coded too: the crc high byte then
// low byte when append_crc is set, two 0x0b terminators, and one or two 0x0b pads so the
// packet ends on a whole pair of bytes. Each byte becomes a 16 bit code word from a
// k=4 rate 1/2 code; every pair of words is bit-pair interleaved into four result bytes.
// Pacing: in steady state the input is paced by the byte-wide result port, which drains
// four bytes per pair of input bytes. The byte marked last adds 3 to 6 tail bytes; the
// input stays stalled while they are fed, paced by the output port, and up to 16 results
// come from a packet's last word. The first result byte of a pair is presented once the
// second input word of the pair has passed the input register and then the output buffer
// register, when the output buffer is free.
// Registers: byte address 0 append_crc (bit 0, reset 1), address 4 crc_polynomial
// (bits 15:0, reset 0x8005); write only between packets.
module fec_convolutional_interleave_encoder (
   input  logic                 clock,
   input  logic                 reset,
   // input channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  fci_pkg::fci_req_type req_word,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output fci_pkg::fci_rsp_type rsp_word,
   // configuration port
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import fci_pkg::*;

   logic         append_crc_ff, append_crc_in;
   logic [15:0]  crc_poly_ff, crc_poly_in;
   logic         csr_write;
   logic         reg_sel;
   fci_feed_type feed;
   fci_load_type load;
   logic         feed_take;
   logic         phase;
   logic         load_ok;

   // register file, word aligned, register index in address bit 2
   assign pready    = 1'b1;
   assign reg_sel   = paddr[2];
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      append_crc_in = append_crc_ff;
      crc_poly_in   = crc_poly_ff;
      if (csr_write) begin
         case (reg_sel)
            REG_APPEND_CRC: append_crc_in = pwdata[0];
            REG_CRC_POLY:   crc_poly_in   = pwdata[15:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_APPEND_CRC: prdata = {31'd0, append_crc_ff};
         REG_CRC_POLY:   prdata = {16'd0, crc_poly_ff};
         default:        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         append_crc_ff <= 1'b1;
         crc_poly_ff   <= CRC_POLY_INIT;
      end else begin
         append_crc_ff <= append_crc_in;
         crc_poly_ff   <= crc_poly_in;
      end
   end

   // input register, crc and tail bytes
   fci_tail_seq u_tail_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word       (req_word),
      .append_crc     (append_crc_ff),
      .crc_polynomial (crc_poly_ff),
      .phase          (phase),
      .feed_take      (feed_take),
      .feed           (feed)
   );

   // code word per byte, interleave per pair
   fci_coder u_coder (
      .clock     (clock),
      .reset     (reset),
      .feed      (feed),
      .feed_take (feed_take),
      .phase     (phase),
      .load_ok   (load_ok),
      .load      (load)
   );

   // four bytes out, one per cycle while the result channel is not stalled
   fci_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .load_ok   (load_ok),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

/* dv/fci_coded_byte_checker.sv */
// checker: predicts the coded byte stream from the watched channels and compares it
`timescale 1ns / 1ps
module fci_coded_byte_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  fci_pkg::fci_req_type req_word,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  fci_pkg::fci_rsp_type rsp_word,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic                 pready,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output int                   mismatch_count,
   output int                   bytes_due
);
   import fci_pkg::*;

   // code symbol per {input bit, three memory bits}
   localparam logic [1:0] SYMBOL_MAP [16] = '{
      2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1,
      2'd3, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd1, 2'd2
   };
   localparam logic [15:0] POLY_AT_RESET = 16'h8005;

   logic [2:0]  coder_mem;
   logic [15:0] crc_acc;
   logic [15:0] first_word;
   logic        have_first;
   logic        crc_enable;
   logic [15:0] crc_poly;
   fci_rsp_type coded_bytes_due [$];

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d,
                                            input logic [15:0] poly);
      logic [15:0] c;
      logic [7:0]  s;
      logic        fb;
      c = crc;
      s = d;
      for (int k = 0; k < 8; k++) begin
         fb = c[15] ^ s[7];
         c  = {c[14:0], 1'b0} ^ (fb ? poly : 16'h0000);
         s  = {s[6:0], 1'b0};
      end
      return c;
   endfunction

   // code one byte; every second byte releases four interleaved bytes
   task automatic code_one(input logic [7:0] b, input logic mark_last);
      logic [10:0] sr;
      logic [15:0] w;
      logic [31:0] v;
      logic [7:0]  f [4];
      fci_rsp_type r;
      sr = {coder_mem, b};
      w  = '0;
      for (int k = 0; k < 8; k++) begin
         w  = {w[13:0], SYMBOL_MAP[sr[10:7]]};
         sr = {sr[9:0], 1'b0};
      end
      coder_mem = sr[10:8];
      if (!have_first) begin
         first_word = w;
         have_first = 1'b1;
      end else begin
         f[0] = first_word[15:8];
         f[1] = first_word[7:0];
         f[2] = w[15:8];
         f[3] = w[7:0];
         v = '0;
         for (int j = 0; j < 16; j++) begin
            v = {v[29:0], f[3 - (j % 4)][2 * (j / 4) +: 2]};
         end
         for (int n = 0; n < 4; n++) begin
            r.coded_byte    = v[24 - 8 * n +: 8];
            r.end_of_packet = mark_last && (n == 3);
            coded_bytes_due.push_back(r);
         end
         have_first = 1'b0;
      end
   endtask

   task automatic encode_word(input fci_req_type w);
      crc_acc = crc_byte(crc_acc, w.data_byte, crc_poly);
      code_one(w.data_byte, 1'b0);
      if (w.last_byte) begin
         if (crc_enable) begin
            code_one(crc_acc[15:8], 1'b0);
            code_one(crc_acc[7:0], 1'b0);
         end
         code_one(TERM_BYTE, 1'b0);
         code_one(TERM_BYTE, 1'b0);
         // pad to a whole pair
         if (!have_first) begin
            code_one(TERM_BYTE, 1'b0);
         end
         code_one(TERM_BYTE, 1'b1);
         coder_mem  = '0;
         crc_acc    = CRC_INIT;
         have_first = 1'b0;
      end
   endtask

   always @(posedge clock) begin : watch
      fci_rsp_type want;
      if (reset) begin
         coder_mem  = '0;
         crc_acc    = CRC_INIT;
         first_word = '0;
         have_first = 1'b0;
         crc_enable = 1'b1;
         crc_poly   = POLY_AT_RESET;
         coded_bytes_due.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (coded_bytes_due.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("unexpected coded byte %02h eop %0d", rsp_word.coded_byte,
                           rsp_word.end_of_packet);
               end
               mismatch_count++;
            end else begin
               want = coded_bytes_due.pop_front();
               if (want.coded_byte !== rsp_word.coded_byte ||
                   want.end_of_packet !== rsp_word.end_of_packet) begin
                  if (mismatch_count < 10) begin
                     $display("coded byte exp %02h got %02h, eop exp %0d got %0d",
                              want.coded_byte, rsp_word.coded_byte,
                              want.end_of_packet, rsp_word.end_of_packet);
                  end
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            encode_word(req_word);
         end
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_APPEND_CRC) begin
               crc_enable = pwdata[0];
            end else if (paddr[2] == REG_CRC_POLY) begin
               crc_poly = pwdata[15:0];
            end
         end
      end
      bytes_due = coded_bytes_due.size();
   end

endmodule

/* dv/tb_fec_convolutional_interleave_encoder.sv */
// testbench top: stimulus, idling and verdict for the convolutional interleave encoder
`timescale 1ns / 1ps
module tb_fec_convolutional_interleave_encoder;
   import fci_pkg::*;

   // far above the slowest correct run of this stimulus
   localparam int CYCLE_LIMIT  = 200000;
   localparam int ITEM_TARGET  = 330;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE_TICKS = 12;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   fci_req_type req_word;
   logic        rsp_valid;
   logic        rsp_stall;
   fci_rsp_type rsp_word;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int mismatch_count;
   int bytes_due;

   // no idling on either side while set
   bit quiet;
   // bumped by the stimulus to ask the receiver for one long hold-off
   int hold_requests;
   int words_sent;

   fec_convolutional_interleave_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   fci_coded_byte_checker coded_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word       (rsp_word),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .mismatch_count (mismatch_count),
      .bytes_due      (bytes_due)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // cycle limit: a hung block or a lost byte ends here
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   // receiver: random stall, or a long counted hold-off on request
   initial begin : rsp_side
      int hold_left;
      int hold_seen;
      rsp_stall = 1'b0;
      hold_left = 0;
      hold_seen = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 16);
         end
      end
   end

   // offer one word, holding it until accepted; called and returns at a falling edge
   task automatic send_word(input logic [7:0] d, input logic l);
      if (!quiet) begin
         while ($urandom_range(99) < 16) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid          <= 1'b1;
      req_word.data_byte <= d;
      req_word.last_byte <= l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   // one packet of random bytes, extremes mixed in
   task automatic send_packet(input int len);
      logic [7:0] d;
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(7))
            0:       d = 8'h00;
            1:       d = 8'hFF;
            default: d = 8'($urandom_range(255));
         endcase
         send_word(d, i == len - 1);
      end
   endtask

   // sender stops until every predicted byte is out, then lets the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (bytes_due != 0) @(negedge clock);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   // setup then access phase; the register lands at the access edge
   task automatic csr_write(input logic idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // random setting, extremes of the polynomial now and then; upper pwdata bits are noise
   task automatic random_config();
      logic [15:0] poly;
      case ($urandom_range(5))
         0:       poly = 16'h0000;
         1:       poly = 16'hFFFF;
         2:       poly = 16'h8005;
         default: poly = 16'($urandom_range(16'hFFFF));
      endcase
      csr_write(REG_APPEND_CRC, {16'($urandom_range(16'hFFFF)), 15'h0000,
                                 1'($urandom_range(1))});
      csr_write(REG_CRC_POLY, {16'($urandom_range(16'hFFFF)), poly});
   endtask

   initial begin : stimulus
      int phase;
      int n_packets;
      int len;
      req_valid     = 1'b0;
      req_word      = '0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      quiet         = 1'b0;
      hold_requests = 0;
      words_sent    = 0;
      reset         = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: crc appended, 0x8005; one-byte packets give an odd count,
      // two-byte ones an even count, so both pad lengths show up
      send_word(8'h00, 1'b1);
      send_word(8'hFF, 1'b1);
      send_word(8'h55, 1'b0);
      send_word(8'hAA, 1'b1);
      drain();

      // no crc: tail is terminators and pad only
      csr_write(REG_APPEND_CRC, 32'h0000_0000);
      csr_write(REG_CRC_POLY, 32'h0000_1021);
      send_word(8'h00, 1'b1);
      send_word(8'hFF, 1'b0);
      send_word(8'h80, 1'b1);
      send_word(8'h01, 1'b0);
      send_word(8'h7F, 1'b0);
      send_word(8'hFE, 1'b1);
      drain();

      // polynomial extremes
      csr_write(REG_APPEND_CRC, 32'h0000_0001);
      csr_write(REG_CRC_POLY, 32'h0000_0000);
      send_word(8'hFF, 1'b0);
      send_word(8'hFF, 1'b1);
      send_word(8'h00, 1'b1);
      drain();
      csr_write(REG_CRC_POLY, 32'hFFFF_FFFF);
      send_word(8'hA5, 1'b0);
      send_word(8'h5A, 1'b0);
      send_word(8'h3C, 1'b1);
      send_word(8'hC3, 1'b1);
      drain();

      // random phases, each under its own setting and ending with the sender idle
      phase = 0;
      while (words_sent < ITEM_TARGET) begin
         random_config();
         quiet = (phase == 2);
         if (phase == 1) begin
            // long receiver hold-off while long packets keep coming: the block backs up
            hold_requests++;
            for (int p = 0; p < 4; p++) begin
               send_packet($urandom_range(8, 14));
            end
         end
         n_packets = $urandom_range(4, 8);
         for (int p = 0; p < n_packets; p++) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
            send_packet(len);
         end
         drain();
         quiet = 1'b0;
         phase++;
      end

      if (mismatch_count == 0 && bytes_due == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
